/* hw/rtl/ecc_pkg.sv */
// Shared types and constants for the evaporative cooler controller.
// Depends on nothing; used by every module under hw/rtl.
`default_nettype none

package ecc_pkg;

   typedef enum logic [1:0] {
      CLS_COLD = 2'd0,
      CLS_COOL = 2'd1,
      CLS_HOT  = 2'd2
   } temp_class_type;

   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_ON   = 2'd1,
      MODE_SLOW = 2'd2
   } blower_mode_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_TEMP  = 3'd0,
      CSR_TEMP_SWING   = 3'd1,
      CSR_TARGET_HUMID = 3'd2,
      CSR_TARGET_HSWING = 3'd3,
      CSR_MAX_HUMID    = 3'd4,
      CSR_MAX_HSWING   = 3'd5
   } csr_index_type;

   localparam logic [6:0] RST_TARGET_TEMP   = 7'd67;
   localparam logic [4:0] RST_TEMP_SWING    = 5'd5;
   localparam logic [6:0] RST_TARGET_HUMID  = 7'd90;
   localparam logic [6:0] RST_TARGET_HSWING = 7'd10;
   localparam logic [6:0] RST_MAX_HUMID     = 7'd80;
   localparam logic [6:0] RST_MAX_HSWING    = 7'd20;

   // Light codes, nibbles red/green/blue/white
   localparam logic [15:0] COL_NONE    = 16'h0000;
   localparam logic [15:0] COL_RED     = 16'h1000;
   localparam logic [15:0] COL_BLUE    = 16'h0010;
   localparam logic [15:0] COL_YELLOW  = 16'h1100;
   localparam logic [15:0] COL_GREEN   = 16'h0100;
   localparam logic [15:0] COL_MAGENTA = 16'h1010;
   localparam logic [15:0] COL_GREY    = 16'h0001;
   localparam logic [15:0] COL_WHITE   = 16'h1110;

   // Classified sample handed from front to back
   typedef struct packed {
      temp_class_type outside_cls;
      temp_class_type blower_cls;
      logic           inside_hot;
      logic           inside_wet;
      logic           blower_wet;
      logic           reservoir_low;
   } class_item_type;

   typedef struct packed {
      blower_mode_type blower_mode;
      logic            bilge_pump_on;
      logic            refill_pump_on;
      logic [15:0]     primary_color;
      logic [15:0]     secondary_color;
      logic            alert_on;
      logic            refill_light;
   } rsp_item_type;

endpackage

`default_nettype wire

/* hw/rtl/ecc_front.sv */
// Front end: configuration registers and hysteresis classification.
// Depends on ecc_pkg. Produces one class_item_type per accepted sample.
`default_nettype none

module ecc_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write,
   input  wire logic [ecc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ecc_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire logic                               take,
   input  wire logic signed [8:0]                  outside_temp,
   input  wire logic [6:0]                         outside_humid,
   input  wire logic signed [8:0]                  inside_temp,
   input  wire logic [6:0]                         inside_humid,
   input  wire logic signed [8:0]                  blower_temp,
   input  wire logic [6:0]                         blower_humid,
   input  wire logic                               reservoir_low,
   output ecc_pkg::class_item_type                 item
);

   logic [6:0] target_temp_ff;
   logic [4:0] temp_swing_ff;
   logic [6:0] target_humid_ff;
   logic [6:0] target_hswing_ff;
   logic [6:0] max_humid_ff;
   logic [6:0] max_hswing_ff;

   ecc_pkg::temp_class_type outside_cls_ff, outside_cls_in;
   ecc_pkg::temp_class_type blower_cls_ff, blower_cls_in;
   logic inside_hot_ff, inside_hot_in;
   logic outside_wet_ff, outside_wet_in;
   logic blower_wet_ff, blower_wet_in;
   logic inside_wet_ff, inside_wet_in;

   logic signed [10:0] o_t, i_t, b_t, tt, ts, tt_lo, tt_hi, in_lo;
   logic signed [8:0]  o_h, i_h, b_h, th, th_lo, mh, mh_lo;

   function automatic ecc_pkg::temp_class_type next_class(
      input ecc_pkg::temp_class_type cls,
      input logic signed [10:0]      t,
      input logic signed [10:0]      in_t,
      input logic signed [10:0]      tgt,
      input logic signed [10:0]      tgt_lo,
      input logic signed [10:0]      in_t_lo
   );
      ecc_pkg::temp_class_type c;
      c = cls;
      if (c == ecc_pkg::CLS_COLD && t > tgt) c = ecc_pkg::CLS_COOL;
      if (c == ecc_pkg::CLS_COOL) begin
         if (t > in_t) c = ecc_pkg::CLS_HOT;
         if (t < tgt_lo) c = ecc_pkg::CLS_COLD;
      end
      if (c == ecc_pkg::CLS_HOT && t < in_t_lo) c = ecc_pkg::CLS_COOL;
      return c;
   endfunction

   // registers are written as-is, masked to width
   always_ff @(posedge clock) begin
      if (reset) begin
         target_temp_ff   <= ecc_pkg::RST_TARGET_TEMP;
         temp_swing_ff    <= ecc_pkg::RST_TEMP_SWING;
         target_humid_ff  <= ecc_pkg::RST_TARGET_HUMID;
         target_hswing_ff <= ecc_pkg::RST_TARGET_HSWING;
         max_humid_ff     <= ecc_pkg::RST_MAX_HUMID;
         max_hswing_ff    <= ecc_pkg::RST_MAX_HSWING;
      end else if (csr_write) begin
         unique case (csr_index)
            ecc_pkg::CSR_TARGET_TEMP:   target_temp_ff   <= csr_data;
            ecc_pkg::CSR_TEMP_SWING:    temp_swing_ff    <= csr_data[4:0];
            ecc_pkg::CSR_TARGET_HUMID:  target_humid_ff  <= csr_data;
            ecc_pkg::CSR_TARGET_HSWING: target_hswing_ff <= csr_data;
            ecc_pkg::CSR_MAX_HUMID:     max_humid_ff     <= csr_data;
            ecc_pkg::CSR_MAX_HSWING:    max_hswing_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      o_t   = 11'(outside_temp);
      i_t   = 11'(inside_temp);
      b_t   = 11'(blower_temp);
      tt    = $signed({4'b0, target_temp_ff});
      ts    = $signed({6'b0, temp_swing_ff});
      tt_lo = tt - ts;
      tt_hi = tt + ts;
      in_lo = i_t - ts;
      o_h   = $signed({2'b0, outside_humid});
      i_h   = $signed({2'b0, inside_humid});
      b_h   = $signed({2'b0, blower_humid});
      th    = $signed({2'b0, target_humid_ff});
      th_lo = th - $signed({2'b0, target_hswing_ff});
      mh    = $signed({2'b0, max_humid_ff});
      mh_lo = mh - $signed({2'b0, max_hswing_ff});

      outside_cls_in = next_class(outside_cls_ff, o_t, i_t, tt, tt_lo, in_lo);
      blower_cls_in  = next_class(blower_cls_ff, b_t, i_t, tt, tt_lo, in_lo);

      if (!inside_hot_ff) inside_hot_in = (i_t > tt_hi);
      else                inside_hot_in = !(i_t <= tt);

      // outside and blower rise at >=, inside rises only strictly above
      outside_wet_in = outside_wet_ff ? !(o_h < th_lo) : (o_h >= th);
      blower_wet_in  = blower_wet_ff  ? !(b_h < th_lo) : (b_h >= th);
      inside_wet_in  = inside_wet_ff  ? !(i_h < mh_lo) : (i_h > mh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outside_cls_ff <= ecc_pkg::CLS_HOT;
         blower_cls_ff  <= ecc_pkg::CLS_HOT;
         inside_hot_ff  <= 1'b1;
         outside_wet_ff <= 1'b0;
         blower_wet_ff  <= 1'b0;
         inside_wet_ff  <= 1'b0;
      end else if (take) begin
         outside_cls_ff <= outside_cls_in;
         blower_cls_ff  <= blower_cls_in;
         inside_hot_ff  <= inside_hot_in;
         outside_wet_ff <= outside_wet_in;
         blower_wet_ff  <= blower_wet_in;
         inside_wet_ff  <= inside_wet_in;
      end
   end

   always_comb begin
      item.outside_cls   = outside_cls_in;
      item.blower_cls    = blower_cls_in;
      item.inside_hot    = inside_hot_in;
      item.inside_wet    = inside_wet_in;
      item.blower_wet    = blower_wet_in;
      item.reservoir_low = reservoir_low;
   end

endmodule

`default_nettype wire

/* hw/rtl/ecc_class_queue.sv */
// Two-entry queue of classified samples between front and back.
// Depends on ecc_pkg (class_item_type).
`default_nettype none

module ecc_class_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire ecc_pkg::class_item_type  push_item,
   output logic                          full,
   input  wire logic                     pop,
   output ecc_pkg::class_item_type       pop_item,
   output logic                          empty
);

   ecc_pkg::class_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      full     = (count_ff == 2'd2);
      empty    = (count_ff == 2'd0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_item = entry_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

`default_nettype wire

/* hw/rtl/ecc_back.sv */
// Back end: priority table from classes to actuator and light commands,
// followed by a two-entry result queue. Depends on ecc_pkg.
`default_nettype none

module ecc_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ecc_pkg::class_item_type  cls_item,
   input  wire logic                     cls_empty,
   output logic                          cls_pop,
   input  wire logic                     rsp_pop,
   output logic                          rsp_empty,
   output ecc_pkg::rsp_item_type         rsp_item
);

   ecc_pkg::rsp_item_type res;
   ecc_pkg::rsp_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       out_full, do_push, do_pop;
   logic       low;

   always_comb begin
      low = cls_item.reservoir_low;
      res = '0;
      res.blower_mode = ecc_pkg::MODE_OFF;
      if (cls_item.inside_hot && cls_item.inside_wet &&
          cls_item.outside_cls == ecc_pkg::CLS_HOT) begin
         // overhumid shutdown wins over refill
         res.primary_color   = ecc_pkg::COL_RED;
         res.secondary_color = ecc_pkg::COL_BLUE;
         res.alert_on        = 1'b1;
      end else begin
         res.refill_pump_on = low;
         res.refill_light   = low;
         if (!cls_item.inside_hot) begin
            res.primary_color = ecc_pkg::COL_NONE;
         end else if (cls_item.outside_cls == ecc_pkg::CLS_COLD) begin
            res.blower_mode   = ecc_pkg::MODE_ON;
            res.primary_color = ecc_pkg::COL_GREY;
         end else if (cls_item.outside_cls == ecc_pkg::CLS_COOL) begin
            res.blower_mode = ecc_pkg::MODE_ON;
            if (cls_item.inside_wet) begin
               res.primary_color = ecc_pkg::COL_MAGENTA;
            end else begin
               res.primary_color = ecc_pkg::COL_GREEN;
               if (!low && !cls_item.blower_wet) begin
                  res.bilge_pump_on   = 1'b1;
                  res.secondary_color = ecc_pkg::COL_BLUE;
               end
            end
         end else if (cls_item.blower_cls == ecc_pkg::CLS_HOT) begin
            res.blower_mode = ecc_pkg::MODE_SLOW;
            res.alert_on    = 1'b1;
            if (cls_item.blower_wet) begin
               res.primary_color = ecc_pkg::COL_RED;
            end else if (!low) begin
               res.bilge_pump_on = 1'b1;
               res.primary_color = ecc_pkg::COL_BLUE;
            end else begin
               res.primary_color = ecc_pkg::COL_YELLOW;
            end
         end else begin
            res.blower_mode   = ecc_pkg::MODE_ON;
            res.primary_color = (cls_item.blower_cls == ecc_pkg::CLS_COOL) ?
                                ecc_pkg::COL_YELLOW : ecc_pkg::COL_WHITE;
            if (!low && !cls_item.blower_wet) begin
               res.bilge_pump_on   = 1'b1;
               res.secondary_color = ecc_pkg::COL_BLUE;
            end
         end
      end
   end

   // result queue
   always_comb begin
      out_full  = (count_ff == 2'd2);
      rsp_empty = (count_ff == 2'd0);
      do_push   = !cls_empty && !out_full;
      cls_pop   = do_push;
      do_pop    = rsp_pop && !rsp_empty;
      rsp_item  = entry_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= res;
   end

endmodule

`default_nettype wire

/* hw/rtl/evaporative_cooler_controller_top.sv */
// Top level of the evaporative cooler controller.
// Depends on ecc_pkg, ecc_front, ecc_class_queue and ecc_back.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   req      | req_push / req_full | six sensor readings, reservoir_low flag
//   rsp      | rsp_pop / rsp_empty | blower mode, pumps, colors, alert, refill
//   csr      | csr_valid/csr_ready | csr_index (0..5), csr_data
//
// One sample per cycle sustained while rsp_pop drains results; a result passes
// through the class queue and then the result queue before it can be popped on rsp
// (front classifies on acceptance, back runs the table on the class queue head). Each
// side owns a two-entry queue, so a stalled rsp side backs up into req_full only after
// four samples are held. Synchronous reset restores the register defaults and hysteresis
// classes and empties both queues. csr_ready is always high.
`default_nettype none

module evaporative_cooler_controller_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ecc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ecc_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic signed [8:0]               req_outside_temp,
   input  wire logic [6:0]                      req_outside_humid,
   input  wire logic signed [8:0]               req_inside_temp,
   input  wire logic [6:0]                      req_inside_humid,
   input  wire logic signed [8:0]               req_blower_temp,
   input  wire logic [6:0]                      req_blower_humid,
   input  wire logic                            req_reservoir_low,
   input  wire logic                            rsp_pop,
   output logic                                 rsp_empty,
   output logic [1:0]                           rsp_blower_mode,
   output logic                                 rsp_bilge_pump_on,
   output logic                                 rsp_refill_pump_on,
   output logic [15:0]                          rsp_primary_color,
   output logic [15:0]                          rsp_secondary_color,
   output logic                                 rsp_alert_on,
   output logic                                 rsp_refill_light
);

   ecc_pkg::class_item_type front_item, queue_item;
   ecc_pkg::rsp_item_type   rsp_item;
   logic take, q_empty, q_pop;

   assign csr_ready = 1'b1;
   assign take      = req_push && !req_full;

   ecc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .take          (take),
      .outside_temp  (req_outside_temp),
      .outside_humid (req_outside_humid),
      .inside_temp   (req_inside_temp),
      .inside_humid  (req_inside_humid),
      .blower_temp   (req_blower_temp),
      .blower_humid  (req_blower_humid),
      .reservoir_low (req_reservoir_low),
      .item          (front_item)
   );

   ecc_class_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (front_item),
      .full      (req_full),
      .pop       (q_pop),
      .pop_item  (queue_item),
      .empty     (q_empty)
   );

   ecc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_item  (queue_item),
      .cls_empty (q_empty),
      .cls_pop   (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item)
   );

   assign rsp_blower_mode     = rsp_item.blower_mode;
   assign rsp_bilge_pump_on   = rsp_item.bilge_pump_on;
   assign rsp_refill_pump_on  = rsp_item.refill_pump_on;
   assign rsp_primary_color   = rsp_item.primary_color;
   assign rsp_secondary_color = rsp_item.secondary_color;
   assign rsp_alert_on        = rsp_item.alert_on;
   assign rsp_refill_light    = rsp_item.refill_light;

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && q_empty)
      else $error("queues not empty after reset");

   // refill indication always follows the refill pump
   a_refill_pair: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_refill_light == rsp_refill_pump_on)
      else $error("refill light and pump disagree");

   // alert only with the blower off or slow
   a_alert_mode: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_alert_on) |->
         (rsp_blower_mode == ecc_pkg::MODE_OFF || rsp_blower_mode == ecc_pkg::MODE_SLOW))
      else $error("alert with blower fully on");

   // a sample entering an idle block reaches the result side through the class queue and the result queue
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (take && q_empty && rsp_empty && !rsp_pop) |-> ##2 !rsp_empty)
      else $error("sample lost between front and back");

endmodule

`default_nettype wire

/* bench/evaporative_cooler_controller_top_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for evaporative_cooler_controller_top: sensor readings are pushed in,
// and a local copy of the hysteresis and priority logic predicts every command set popped out.
// Depends on ecc_pkg and the RTL under hw/rtl.

module evaporative_cooler_controller_top_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int LONG_HOLD      = 300;
   localparam int RANDOM_PER_PHASE = 154;
   localparam int PHASES         = 8;

   // Indexes with no register behind them
   localparam logic [ecc_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED_A = 3'd6;
   localparam logic [ecc_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED_B = 3'd7;

   typedef struct {
      logic signed [8:0] outside_temp;
      logic [6:0]        outside_humid;
      logic signed [8:0] inside_temp;
      logic [6:0]        inside_humid;
      logic signed [8:0] blower_temp;
      logic [6:0]        blower_humid;
      logic              reservoir_low;
   } sensor_reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [ecc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ecc_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   logic              req_push = 1'b0;
   logic              req_full;
   logic signed [8:0] req_outside_temp = '0;
   logic [6:0]        req_outside_humid = '0;
   logic signed [8:0] req_inside_temp = '0;
   logic [6:0]        req_inside_humid = '0;
   logic signed [8:0] req_blower_temp = '0;
   logic [6:0]        req_blower_humid = '0;
   logic              req_reservoir_low = 1'b0;

   logic        rsp_pop = 1'b0;
   logic        rsp_empty;
   logic [1:0]  rsp_blower_mode;
   logic        rsp_bilge_pump_on;
   logic        rsp_refill_pump_on;
   logic [15:0] rsp_primary_color;
   logic [15:0] rsp_secondary_color;
   logic        rsp_alert_on;
   logic        rsp_refill_light;

   evaporative_cooler_controller_top u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_outside_temp    (req_outside_temp),
      .req_outside_humid   (req_outside_humid),
      .req_inside_temp     (req_inside_temp),
      .req_inside_humid    (req_inside_humid),
      .req_blower_temp     (req_blower_temp),
      .req_blower_humid    (req_blower_humid),
      .req_reservoir_low   (req_reservoir_low),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_blower_mode     (rsp_blower_mode),
      .rsp_bilge_pump_on   (rsp_bilge_pump_on),
      .rsp_refill_pump_on  (rsp_refill_pump_on),
      .rsp_primary_color   (rsp_primary_color),
      .rsp_secondary_color (rsp_secondary_color),
      .rsp_alert_on        (rsp_alert_on),
      .rsp_refill_light    (rsp_refill_light)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Local copy of the controller registers and hysteresis state
   logic [6:0] target_temp_r;
   logic [4:0] temp_swing_r;
   logic [6:0] target_humid_r;
   logic [6:0] target_hswing_r;
   logic [6:0] max_humid_r;
   logic [6:0] max_hswing_r;

   ecc_pkg::temp_class_type outside_cls_m;
   ecc_pkg::temp_class_type blower_cls_m;
   logic                    inside_hot_m;
   logic                    outside_wet_m;
   logic                    blower_wet_m;
   logic                    inside_wet_m;

   sensor_reading_type    pending_readings[$];
   ecc_pkg::rsp_item_type expected_commands[$];

   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int stall_left = 0;
   int gap_left = 0;
   int quiet_cycles = 0;
   bit held;

   // Checks run in a fixed order, so a single reading may move the class twice
   function automatic ecc_pkg::temp_class_type next_temp_class(ecc_pkg::temp_class_type cls,
                                                               int t, int in_t, int tt, int sw);
      ecc_pkg::temp_class_type c;
      c = cls;
      if (c == ecc_pkg::CLS_COLD && t > tt)
         c = ecc_pkg::CLS_COOL;
      if (c == ecc_pkg::CLS_COOL) begin
         if (t > in_t)
            c = ecc_pkg::CLS_HOT;
         if (t < tt - sw)
            c = ecc_pkg::CLS_COLD;
      end
      if (c == ecc_pkg::CLS_HOT && t < in_t - sw)
         c = ecc_pkg::CLS_COOL;
      return c;
   endfunction

   function automatic logic next_wet(logic wet, int h, int thr, int band, bit strict_rise);
      if (!wet)
         return strict_rise ? (h > thr) : (h >= thr);
      return !(h < thr - band);
   endfunction

   // Updates the hysteresis state and returns the command set for one reading
   function automatic ecc_pkg::rsp_item_type predict_commands(sensor_reading_type s);
      int o_t, i_t, b_t, o_h, i_h, b_h, tt, ts;
      ecc_pkg::rsp_item_type r;
      o_t = int'(s.outside_temp);
      i_t = int'(s.inside_temp);
      b_t = int'(s.blower_temp);
      o_h = int'(s.outside_humid);
      i_h = int'(s.inside_humid);
      b_h = int'(s.blower_humid);
      tt  = int'(target_temp_r);
      ts  = int'(temp_swing_r);

      outside_cls_m = next_temp_class(outside_cls_m, o_t, i_t, tt, ts);
      blower_cls_m  = next_temp_class(blower_cls_m, b_t, i_t, tt, ts);
      if (!inside_hot_m) begin
         if (i_t > tt + ts)
            inside_hot_m = 1'b1;
      end else if (i_t <= tt) begin
         inside_hot_m = 1'b0;
      end
      outside_wet_m = next_wet(outside_wet_m, o_h, int'(target_humid_r),
                               int'(target_hswing_r), 1'b0);
      blower_wet_m  = next_wet(blower_wet_m, b_h, int'(target_humid_r),
                               int'(target_hswing_r), 1'b0);
      inside_wet_m  = next_wet(inside_wet_m, i_h, int'(max_humid_r), int'(max_hswing_r), 1'b1);

      r = '0;
      if (inside_hot_m && inside_wet_m && outside_cls_m == ecc_pkg::CLS_HOT) begin
         // overhumid shutdown wins over refill
         r.blower_mode     = ecc_pkg::MODE_OFF;
         r.primary_color   = ecc_pkg::COL_RED;
         r.secondary_color = ecc_pkg::COL_BLUE;
         r.alert_on        = 1'b1;
      end else begin
         r.refill_pump_on  = s.reservoir_low;
         r.refill_light    = s.reservoir_low;
         r.secondary_color = ecc_pkg::COL_NONE;
         if (!inside_hot_m) begin
            r.blower_mode   = ecc_pkg::MODE_OFF;
            r.primary_color = ecc_pkg::COL_NONE;
         end else if (outside_cls_m == ecc_pkg::CLS_COLD) begin
            r.blower_mode   = ecc_pkg::MODE_ON;
            r.primary_color = ecc_pkg::COL_GREY;
         end else if (outside_cls_m == ecc_pkg::CLS_COOL) begin
            r.blower_mode = ecc_pkg::MODE_ON;
            if (inside_wet_m) begin
               r.primary_color = ecc_pkg::COL_MAGENTA;
            end else begin
               r.primary_color = ecc_pkg::COL_GREEN;
               if (!s.reservoir_low && !blower_wet_m) begin
                  r.bilge_pump_on   = 1'b1;
                  r.secondary_color = ecc_pkg::COL_BLUE;
               end
            end
         end else if (blower_cls_m == ecc_pkg::CLS_HOT) begin
            r.blower_mode = ecc_pkg::MODE_SLOW;
            r.alert_on    = 1'b1;
            if (blower_wet_m) begin
               r.primary_color = ecc_pkg::COL_RED;
            end else if (!s.reservoir_low) begin
               r.bilge_pump_on = 1'b1;
               r.primary_color = ecc_pkg::COL_BLUE;
            end else begin
               r.primary_color = ecc_pkg::COL_YELLOW;
            end
         end else begin
            r.blower_mode   = ecc_pkg::MODE_ON;
            r.primary_color = (blower_cls_m == ecc_pkg::CLS_COOL) ?
                              ecc_pkg::COL_YELLOW : ecc_pkg::COL_WHITE;
            if (!s.reservoir_low && !blower_wet_m) begin
               r.bilge_pump_on   = 1'b1;
               r.secondary_color = ecc_pkg::COL_BLUE;
            end
         end
      end
      return r;
   endfunction

   function automatic sensor_reading_type reading(int ot, int oh, int it, int ih, int bt,
                                                  int bh, bit low);
      sensor_reading_type s;
      s.outside_temp  = 9'(ot);
      s.outside_humid = 7'(oh);
      s.inside_temp   = 9'(it);
      s.inside_humid  = 7'(ih);
      s.blower_temp   = 9'(bt);
      s.blower_humid  = 7'(bh);
      s.reservoir_low = low;
      return s;
   endfunction

   // Mostly close to the threshold so the hysteresis keeps moving, sometimes any code
   function automatic logic [8:0] pick_temp(int centre);
      if ($urandom_range(0, 3) == 0)
         return 9'($urandom);
      return 9'(centre + int'($urandom_range(0, 80)) - 40);
   endfunction

   function automatic logic [6:0] pick_humid(int centre);
      if ($urandom_range(0, 3) == 0)
         return 7'($urandom);
      return 7'(centre + int'($urandom_range(0, 50)) - 25);
   endfunction

   function automatic sensor_reading_type random_reading();
      sensor_reading_type s;
      s.outside_temp  = pick_temp(int'(target_temp_r));
      s.inside_temp   = pick_temp(int'(target_temp_r));
      s.blower_temp   = pick_temp(int'(target_temp_r));
      s.outside_humid = pick_humid(int'(target_humid_r));
      s.blower_humid  = pick_humid(int'(target_humid_r));
      s.inside_humid  = pick_humid(int'(max_humid_r));
      s.reservoir_low = 1'($urandom_range(0, 1));
      return s;
   endfunction

   task automatic write_reg(input logic [ecc_pkg::CSR_INDEX_W-1:0] idx, input logic [6:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ecc_pkg::CSR_TARGET_TEMP:   target_temp_r   = val;
         ecc_pkg::CSR_TEMP_SWING:    temp_swing_r    = val[4:0];
         ecc_pkg::CSR_TARGET_HUMID:  target_humid_r  = val;
         ecc_pkg::CSR_TARGET_HSWING: target_hswing_r = val;
         ecc_pkg::CSR_MAX_HUMID:     max_humid_r     = val;
         ecc_pkg::CSR_MAX_HSWING:    max_hswing_r    = val;
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [6:0] tt, input logic [6:0] ts, input logic [6:0] th,
                               input logic [6:0] ths, input logic [6:0] mh,
                               input logic [6:0] mhs);
      write_reg(ecc_pkg::CSR_TARGET_TEMP, tt);
      write_reg(ecc_pkg::CSR_TEMP_SWING, ts);
      write_reg(ecc_pkg::CSR_TARGET_HUMID, th);
      write_reg(ecc_pkg::CSR_TARGET_HSWING, ths);
      write_reg(ecc_pkg::CSR_MAX_HUMID, mh);
      write_reg(ecc_pkg::CSR_MAX_HSWING, mhs);
   endtask

   task automatic flag_mismatch(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
   endtask

   // Sender: offers pending readings, predicts on each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         gap_left = 0;
      end else begin
         held = 1'b0;
         if (req_push && !req_full) begin
            expected_commands.push_back(predict_commands(pending_readings[0]));
            void'(pending_readings.pop_front());
            if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
               gap_left = $urandom_range(1, 18);
         end else begin
            held = req_push;
         end
         if (!held) begin
            if (gap_left > 0) begin
               gap_left--;
               req_push <= 1'b0;
            end else if (pending_readings.size() != 0) begin
               req_outside_temp  <= pending_readings[0].outside_temp;
               req_outside_humid <= pending_readings[0].outside_humid;
               req_inside_temp   <= pending_readings[0].inside_temp;
               req_inside_humid  <= pending_readings[0].inside_humid;
               req_blower_temp   <= pending_readings[0].blower_temp;
               req_blower_humid  <= pending_readings[0].blower_humid;
               req_reservoir_low <= pending_readings[0].reservoir_low;
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each popped command set against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         hold_left = 0;
         stall_left = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_commands.size() == 0) begin
               $display("%0t: result with nothing expected, expected none, actual mode %h color %h",
                        $time, rsp_blower_mode, rsp_primary_color);
               mismatches++;
            end else begin
               if (rsp_blower_mode !== expected_commands[0].blower_mode)
                  flag_mismatch("blower_mode", 16'(expected_commands[0].blower_mode),
                                16'(rsp_blower_mode));
               if (rsp_bilge_pump_on !== expected_commands[0].bilge_pump_on)
                  flag_mismatch("bilge_pump_on", 16'(expected_commands[0].bilge_pump_on),
                                16'(rsp_bilge_pump_on));
               if (rsp_refill_pump_on !== expected_commands[0].refill_pump_on)
                  flag_mismatch("refill_pump_on", 16'(expected_commands[0].refill_pump_on),
                                16'(rsp_refill_pump_on));
               if (rsp_primary_color !== expected_commands[0].primary_color)
                  flag_mismatch("primary_color", expected_commands[0].primary_color,
                                rsp_primary_color);
               if (rsp_secondary_color !== expected_commands[0].secondary_color)
                  flag_mismatch("secondary_color", expected_commands[0].secondary_color,
                                rsp_secondary_color);
               if (rsp_alert_on !== expected_commands[0].alert_on)
                  flag_mismatch("alert_on", 16'(expected_commands[0].alert_on),
                                16'(rsp_alert_on));
               if (rsp_refill_light !== expected_commands[0].refill_light)
                  flag_mismatch("refill_light", 16'(expected_commands[0].refill_light),
                                16'(rsp_refill_light));
               void'(expected_commands.pop_front());
            end
         end
         // long hold-off lets the sender fill both queues until req_full rises
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct)
               stall_left = $urandom_range(1, 18);
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      target_temp_r   = ecc_pkg::RST_TARGET_TEMP;
      temp_swing_r    = ecc_pkg::RST_TEMP_SWING;
      target_humid_r  = ecc_pkg::RST_TARGET_HUMID;
      target_hswing_r = ecc_pkg::RST_TARGET_HSWING;
      max_humid_r     = ecc_pkg::RST_MAX_HUMID;
      max_hswing_r    = ecc_pkg::RST_MAX_HSWING;
      outside_cls_m   = ecc_pkg::CLS_HOT;
      blower_cls_m    = ecc_pkg::CLS_HOT;
      inside_hot_m    = 1'b1;
      outside_wet_m   = 1'b0;
      blower_wet_m    = 1'b0;
      inside_wet_m    = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            1: program_regs(7'd32, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
            2: program_regs(7'd99, 7'd31, 7'd99, 7'd100, 7'd100, 7'd100);
            3: begin
               // writes to unmapped indexes must leave every register alone
               write_reg(CSR_UNMAPPED_A, 7'($urandom));
               write_reg(CSR_UNMAPPED_B, 7'h7F);
               program_regs(7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F);
            end
            4: program_regs(7'd0, 7'h60, 7'd50, 7'd5, 7'd50, 7'd5);
            5, 6: program_regs(7'($urandom_range(32, 99)), 7'($urandom_range(0, 31)),
                               7'($urandom_range(0, 99)), 7'($urandom_range(0, 100)),
                               7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)));
            7: program_regs(7'd67, 7'd5, 7'd90, 7'd10, 7'd80, 7'd20);
            default: ;
         endcase

         if (p == PHASES - 1 || p == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = 15 * $urandom_range(0, 2);
            recv_idle_pct = 15 * $urandom_range(0, 2);
         end
         if (p == 1 || p == 5)
            hold_asks++;

         if (p == 0) begin
            // starts hot/hot/hot/dry; walks through each row of the priority table
            pending_readings.push_back(reading(200, 0, 100, 0, 200, 0, 0));
            pending_readings.push_back(reading(200, 0, 100, 0, 200, 0, 1));
            pending_readings.push_back(reading(200, 0, 100, 0, 200, 127, 0));
            pending_readings.push_back(reading(200, 0, 100, 127, 200, 127, 1));
            pending_readings.push_back(reading(200, 0, 100, 0, 200, 0, 1));
            pending_readings.push_back(reading(-256, 0, 100, 0, 200, 0, 0));
            pending_readings.push_back(reading(-256, 0, 100, 0, 200, 0, 0));
            // cold jumps through cool to hot in one reading
            pending_readings.push_back(reading(100, 0, 70, 0, 60, 0, 0));
            pending_readings.push_back(reading(100, 0, 70, 0, -256, 0, 0));
            pending_readings.push_back(reading(100, 0, 70, 0, -256, 0, 1));
            pending_readings.push_back(reading(100, 0, 60, 0, 60, 0, 1));
            pending_readings.push_back(reading(100, 0, 72, 0, 60, 0, 0));
            pending_readings.push_back(reading(100, 0, 73, 0, 60, 0, 0));
            pending_readings.push_back(reading(100, 90, 73, 80, 60, 89, 0));
            pending_readings.push_back(reading(60, 90, 73, 81, 60, 90, 0));
            pending_readings.push_back(reading(60, 80, 73, 60, 60, 80, 0));
            pending_readings.push_back(reading(60, 79, 73, 59, 60, 79, 0));
            pending_readings.push_back(reading(255, 127, 255, 127, 255, 127, 1));
            pending_readings.push_back(reading(-256, 0, -256, 0, -256, 0, 0));
            pending_readings.push_back(reading(-1, 64, -1, 64, -1, 64, 1));
            pending_readings.push_back(reading(85, 42, 170, 85, -86, 21, 0));
         end
         repeat (RANDOM_PER_PHASE) pending_readings.push_back(random_reading());

         while (pending_readings.size() != 0 || expected_commands.size() != 0)
            @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end

      if (mismatches == 0 && expected_commands.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
